FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AFA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AFA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/afa_pkg.sv
// Types and constants shared by the frame assembler modules.
`timescale 1ns / 1ps
package afa_pkg;

  localparam logic [7:0] DELIM    = 8'h7E;
  localparam logic [7:0] TYPE_TX  = 8'h10;
  localparam logic [7:0] TYPE_LAT = 8'h08;
  localparam logic [7:0] TYPE_RAT = 8'h17;
  localparam logic [7:0] CKS_BASE = 8'hFF;
  localparam logic [7:0] ID_FIRST = 8'h01;
  localparam logic [7:0] ID_LAST  = 8'hFF;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_LAT = 2'd1;
  localparam logic [1:0] KIND_RAT = 2'd2;
  // Headers of this kind describe no frame and are ignored.
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Bit of the options byte that marks an encrypted transmit.
  localparam int OPT_ENCRYPT = 1;

  localparam logic [9:0] LEN_TX  = 10'd14;
  localparam logic [9:0] LEN_LAT = 10'd4;
  localparam logic [9:0] LEN_RAT = 10'd15;

  // Steps of the header byte sequence.
  localparam logic [4:0] STEP_LAT_END = 5'd6;
  localparam logic [4:0] STEP_TX_END  = 5'd16;
  localparam logic [4:0] STEP_RAT_END = 5'd17;
  localparam logic [4:0] STEP_ADDR_LAST = 5'd12;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        close;     // a checksum follows this command
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [7:0]  data;
    logic [63:0] dest_addr64;
    logic [15:0] dest_addr16;
    logic [7:0]  radius;
    logic [7:0]  tx_options;
    logic [7:0]  at_cmd_hi;
    logic [7:0]  at_cmd_lo;
    logic [8:0]  payload_len;
  } entry_t;

endpackage

FILE: hw/rtl/afa_front.sv
// Front end: accepts items, tracks frame state and queues serializer commands.
`timescale 1ns / 1ps
module afa_front #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                q_full,
  input  logic                req_type,
  input  logic [1:0]          frame_kind,
  input  logic [63:0]         dest_addr64,
  input  logic [15:0]         dest_addr16,
  input  logic [7:0]          radius,
  input  logic [7:0]          tx_options,
  input  logic [7:0]          at_cmd_hi,
  input  logic [7:0]          at_cmd_lo,
  input  logic [8:0]          payload_len,
  input  logic [7:0]          data_byte,
  output logic                enq,
  output afa_pkg::entry_t     enq_entry
);

  localparam logic [16:0] LIMIT_PLAIN = 17'(MAX_PAYLOAD);
  localparam logic [16:0] LIMIT_ENC   = (MAX_PAYLOAD >= 4) ? 17'(MAX_PAYLOAD - 4) : 17'd0;

  logic [7:0] frame_id, frame_id_next;
  logic [8:0] bytes_left, bytes_left_next;
  logic       frame_open, frame_open_next;
  logic       dropping, dropping_next;

  logic       accept;
  logic [8:0] left_dec;
  logic [16:0] limit;
  logic       too_long;

  assign accept   = push && !q_full;
  assign left_dec = (bytes_left != 9'd0) ? bytes_left - 9'd1 : 9'd0;
  assign limit    = tx_options[afa_pkg::OPT_ENCRYPT] ? LIMIT_ENC : LIMIT_PLAIN;
  assign too_long = (frame_kind == afa_pkg::KIND_TX) && ({8'd0, payload_len} > limit);

  always_comb begin
    frame_id_next   = frame_id;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    dropping_next   = dropping;
    enq             = 1'b0;
    enq_entry.cmd         = afa_pkg::CMD_HDR;
    enq_entry.close       = 1'b0;
    enq_entry.kind        = frame_kind;
    enq_entry.id          = frame_id;
    enq_entry.data        = data_byte;
    enq_entry.dest_addr64 = dest_addr64;
    enq_entry.dest_addr16 = dest_addr16;
    enq_entry.radius      = radius;
    enq_entry.tx_options  = tx_options;
    enq_entry.at_cmd_hi   = at_cmd_hi;
    enq_entry.at_cmd_lo   = at_cmd_lo;
    enq_entry.payload_len = payload_len;
    if (accept) begin
      if (req_type) begin
        if (dropping) begin
          bytes_left_next = left_dec;
          if (left_dec == 9'd0) begin
            dropping_next = 1'b0;
          end
        end else if (frame_open) begin
          bytes_left_next = left_dec;
          enq             = 1'b1;
          enq_entry.cmd   = afa_pkg::CMD_DATA;
          enq_entry.close = (left_dec == 9'd0);
          if (left_dec == 9'd0) begin
            frame_open_next = 1'b0;
          end
        end
      end else if (frame_kind != afa_pkg::KIND_NONE) begin
        enq = 1'b1;
        if (too_long) begin
          // Rejected frame: its payload items are swallowed, no ID is used.
          enq_entry.cmd   = afa_pkg::CMD_ERR;
          dropping_next   = 1'b1;
          frame_open_next = 1'b0;
          bytes_left_next = payload_len;
        end else begin
          enq_entry.cmd   = afa_pkg::CMD_HDR;
          enq_entry.close = (payload_len == 9'd0);
          dropping_next   = 1'b0;
          frame_open_next = (payload_len != 9'd0);
          bytes_left_next = payload_len;
          frame_id_next   = (frame_id == afa_pkg::ID_LAST) ? afa_pkg::ID_FIRST
                                                           : frame_id + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id   <= afa_pkg::ID_FIRST;
      bytes_left <= 9'd0;
      frame_open <= 1'b0;
      dropping   <= 1'b0;
    end else begin
      frame_id   <= frame_id_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
      dropping   <= dropping_next;
    end
  end

endmodule

FILE: hw/rtl/afa_cmd_queue.sv
// Short command queue between the front end and the serializer.
`timescale 1ns / 1ps
module afa_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            enq,
  input  afa_pkg::entry_t enq_entry,
  input  logic            deq,
  output logic            q_full,
  output logic            q_empty,
  output afa_pkg::entry_t head
);

  afa_pkg::entry_t mem [afa_pkg::QDEPTH];
  logic [afa_pkg::QPTR_W-1:0] wptr, rptr;
  logic [afa_pkg::QPTR_W:0]   count;
  logic do_enq, do_deq;

  assign q_full  = (count == (afa_pkg::QPTR_W+1)'(afa_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign head    = mem[rptr];
  assign do_enq  = enq && !q_full;
  assign do_deq  = deq && !q_empty;

  always_ff @(posedge clk) begin
    if (do_enq) begin
      mem[wptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_enq) begin
        wptr <= wptr + 1'b1;
      end
      if (do_deq) begin
        rptr <= rptr + 1'b1;
      end
      if (do_enq && !do_deq) begin
        count <= count + 1'b1;
      end else if (do_deq && !do_enq) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/afa_back.sv
// Serializer: turns queued commands into frame bytes and appends the checksum.
`timescale 1ns / 1ps
module afa_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  afa_pkg::entry_t head,
  output logic            deq,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            status
);

  afa_pkg::entry_t cur;
  logic       busy;
  logic       cks;
  logic [4:0] step;
  logic [7:0] sum;
  logic       out_valid;

  logic       out_ready, adv, at_hdr_end, at_end, done;
  logic [4:0] last_step;
  logic [9:0] len;
  logic [7:0] type_byte;
  logic [2:0] addr_sel;
  logic [63:0] addr_shift;
  logic [7:0] byte_val;
  logic       last_val, status_val;

  assign out_ready = !out_valid || pop;
  assign adv       = busy && out_ready;
  assign empty     = !out_valid;

  always_comb begin
    unique case (cur.kind)
      afa_pkg::KIND_TX: begin
        last_step = afa_pkg::STEP_TX_END;
        len       = afa_pkg::LEN_TX + {1'b0, cur.payload_len};
        type_byte = afa_pkg::TYPE_TX;
      end
      afa_pkg::KIND_LAT: begin
        last_step = afa_pkg::STEP_LAT_END;
        len       = afa_pkg::LEN_LAT + {1'b0, cur.payload_len};
        type_byte = afa_pkg::TYPE_LAT;
      end
      default: begin
        last_step = afa_pkg::STEP_RAT_END;
        len       = afa_pkg::LEN_RAT + {1'b0, cur.payload_len};
        type_byte = afa_pkg::TYPE_RAT;
      end
    endcase
  end

  // Address bytes go out most significant first on steps 5 through 12.
  assign addr_sel   = 3'(afa_pkg::STEP_ADDR_LAST - step);
  assign addr_shift = cur.dest_addr64 >> {addr_sel, 3'b000};

  always_comb begin
    byte_val   = 8'd0;
    last_val   = 1'b0;
    status_val = 1'b0;
    if (cks) begin
      byte_val = afa_pkg::CKS_BASE - sum;
      last_val = 1'b1;
    end else begin
      unique case (cur.cmd)
        afa_pkg::CMD_DATA: byte_val = cur.data;
        afa_pkg::CMD_ERR: begin
          last_val   = 1'b1;
          status_val = 1'b1;
        end
        default: begin
          case (step)
            5'd0: byte_val = afa_pkg::DELIM;
            5'd1: byte_val = 8'(len >> 8);
            5'd2: byte_val = len[7:0];
            5'd3: byte_val = type_byte;
            5'd4: byte_val = cur.id;
            default: begin
              if (cur.kind == afa_pkg::KIND_LAT) begin
                byte_val = (step == 5'd5) ? cur.at_cmd_hi : cur.at_cmd_lo;
              end else if (step <= afa_pkg::STEP_ADDR_LAST) begin
                byte_val = addr_shift[7:0];
              end else if (step == 5'd13) begin
                byte_val = cur.dest_addr16[15:8];
              end else if (step == 5'd14) begin
                byte_val = cur.dest_addr16[7:0];
              end else if (step == 5'd15) begin
                byte_val = (cur.kind == afa_pkg::KIND_TX) ? cur.radius : cur.tx_options;
              end else if (step == 5'd16) begin
                byte_val = (cur.kind == afa_pkg::KIND_TX) ? cur.tx_options : cur.at_cmd_hi;
              end else begin
                byte_val = cur.at_cmd_lo;
              end
            end
          endcase
        end
      endcase
    end
  end

  assign at_hdr_end = (cur.cmd != afa_pkg::CMD_HDR) || (step == last_step);
  assign at_end     = cks || (at_hdr_end && !cur.close);
  assign done       = adv && at_end;
  assign deq        = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (deq) begin
      cur <= head;
    end
    if (adv) begin
      out_byte <= byte_val;
      last     <= last_val;
      status   <= status_val;
      if (!cks) begin
        if (cur.cmd == afa_pkg::CMD_DATA) begin
          sum <= sum + byte_val;
        end else if (cur.cmd == afa_pkg::CMD_HDR) begin
          // The checksum covers the bytes from the frame type on.
          if (step == 5'd3) begin
            sum <= byte_val;
          end else if (step > 5'd3) begin
            sum <= sum + byte_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cks       <= 1'b0;
      step      <= 5'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= busy;
      end
      if (deq) begin
        busy <= 1'b1;
        cks  <= 1'b0;
        step <= 5'd0;
      end else if (done) begin
        busy <= 1'b0;
        cks  <= 1'b0;
      end else if (adv) begin
        if (at_hdr_end) begin
          cks <= 1'b1;
        end else begin
          step <= step + 5'd1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/api_frame_assembler.sv
// Top level of the API frame assembler.
`timescale 1ns / 1ps
// Builds radio API frames one byte per result item. A header item starts a transmit, local AT
// or remote AT frame; payload items follow and are passed through; a checksum byte with last
// set closes the frame. A transmit header whose payload exceeds MAX_PAYLOAD (four less with
// options bit 1) yields one item with status and last set, and its payload items are dropped.
// Every input item is accepted whenever the four-entry command queue has room. The
// serializer emits one byte per cycle when pop keeps up: a payload item yields one byte
// (and the checksum when it ends the frame), a header 7, 17 or 18 bytes plus the checksum of
// an empty frame, so the byte-wide output sets the sustained rate.
module api_frame_assembler #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [1:0]  frame_kind,
  input  logic [63:0] dest_addr64,
  input  logic [15:0] dest_addr16,
  input  logic [7:0]  radius,
  input  logic [7:0]  tx_options,
  input  logic [7:0]  at_cmd_hi,
  input  logic [7:0]  at_cmd_lo,
  input  logic [8:0]  payload_len,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        status
);

  logic            enq, deq, q_empty;
  afa_pkg::entry_t enq_entry, head;

  afa_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk(clk), .rst(rst), .push(push), .q_full(full),
    .req_type(req_type), .frame_kind(frame_kind), .dest_addr64(dest_addr64),
    .dest_addr16(dest_addr16), .radius(radius), .tx_options(tx_options),
    .at_cmd_hi(at_cmd_hi), .at_cmd_lo(at_cmd_lo), .payload_len(payload_len),
    .data_byte(data_byte), .enq(enq), .enq_entry(enq_entry)
  );

  afa_cmd_queue u_queue (
    .clk(clk), .rst(rst), .enq(enq), .enq_entry(enq_entry), .deq(deq),
    .q_full(full), .q_empty(q_empty), .head(head)
  );

  afa_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .head(head), .deq(deq),
    .pop(pop), .empty(empty), .out_byte(out_byte), .last(last), .status(status)
  );

endmodule

FILE: hw/rtl/afa_checker.sv
// Port-level checker for the frame assembler and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module afa_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       last,
  input logic       status
);

  `AFA_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> empty, "output not empty after reset")
  `AFA_ASSERT_ALWAYS(a_room_after_reset, clk, rst |=> !full, "queue full after reset")
  `AFA_ASSERT(a_reject_is_last, clk, rst,
              (!empty && status) |-> (last && out_byte == 8'd0), "rejection item malformed")
  `AFA_ASSERT(a_result_holds, clk, rst,
              (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)),
              "waiting item changed")

endmodule

bind api_frame_assembler afa_checker u_checker (
  .clk(clk), .rst(rst), .full(full), .pop(pop), .empty(empty),
  .out_byte(out_byte), .last(last), .status(status)
);

FILE: tb/sv/afa_frame_checker.sv
// Checker for the API frame assembler: predicts every frame byte and compares the results.
`timescale 1ns / 1ps
module afa_frame_checker #(
  parameter int MAX_PAYLOAD = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        req_type,
  input  logic [1:0]  frame_kind,
  input  logic [63:0] dest_addr64,
  input  logic [15:0] dest_addr16,
  input  logic [7:0]  radius,
  input  logic [7:0]  tx_options,
  input  logic [7:0]  at_cmd_hi,
  input  logic [7:0]  at_cmd_lo,
  input  logic [8:0]  payload_len,
  input  logic [7:0]  data_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        last,
  input  logic        status,
  output int          fail_count,
  output int          pending,
  output int          frames_built,
  output int          frames_rejected,
  output int          bytes_checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       status;
  } frame_byte_t;

  frame_byte_t frame_bytes_due[$];

  // Predicted state of the assembler.
  logic [7:0] id_next  = afa_pkg::ID_FIRST;
  logic [8:0] left_cnt = '0;
  logic [7:0] cks_sum  = '0;
  logic       in_frame = 1'b0;
  logic       dropping = 1'b0;

  int fails = 0;
  int due_cnt = 0;
  int built_cnt = 0;
  int reject_cnt = 0;
  int checked_cnt = 0;

  assign fail_count      = fails;
  assign pending         = due_cnt;
  assign frames_built    = built_cnt;
  assign frames_rejected = reject_cnt;
  assign bytes_checked   = checked_cnt;

  task automatic queue_byte(input logic [7:0] value, input logic lst, input logic st,
                            input logic add);
    frame_byte_t fb;
    fb.value  = value;
    fb.last   = lst;
    fb.status = st;
    frame_bytes_due.push_back(fb);
    if (add) cks_sum = cks_sum + value;
  endtask

  task automatic close_frame();
    queue_byte(afa_pkg::CKS_BASE - cks_sum, 1'b1, 1'b0, 1'b0);
    in_frame = 1'b0;
  endtask

  task automatic predict_frame_bytes(input logic rq, input logic [1:0] kind,
                                     input logic [63:0] a64, input logic [15:0] a16,
                                     input logic [7:0] rad, input logic [7:0] opt,
                                     input logic [7:0] chi, input logic [7:0] clo,
                                     input logic [8:0] plen, input logic [7:0] db);
    logic [15:0] len;
    logic [7:0]  ftype;
    int          lim;
    if (rq) begin
      if (dropping) begin
        if (left_cnt > 0) left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) dropping = 1'b0;
      end else if (in_frame) begin
        queue_byte(db, 1'b0, 1'b0, 1'b1);
        if (left_cnt > 0) left_cnt = left_cnt - 1'b1;
        if (left_cnt == 0) close_frame();
      end
    end else if (kind != afa_pkg::KIND_NONE) begin
      // A new header abandons whatever frame was open or being dropped.
      in_frame = 1'b0;
      dropping = 1'b0;
      left_cnt = '0;
      lim = MAX_PAYLOAD;
      if (opt[afa_pkg::OPT_ENCRYPT]) lim = (lim >= 4) ? lim - 4 : 0;
      if (kind == afa_pkg::KIND_TX && int'(plen) > lim) begin
        dropping = 1'b1;
        left_cnt = plen;
        queue_byte(8'h00, 1'b1, 1'b1, 1'b0);
        reject_cnt++;
      end else begin
        case (kind)
          afa_pkg::KIND_TX: begin
            len   = 16'(afa_pkg::LEN_TX) + 16'(plen);
            ftype = afa_pkg::TYPE_TX;
          end
          afa_pkg::KIND_LAT: begin
            len   = 16'(afa_pkg::LEN_LAT) + 16'(plen);
            ftype = afa_pkg::TYPE_LAT;
          end
          default: begin
            len   = 16'(afa_pkg::LEN_RAT) + 16'(plen);
            ftype = afa_pkg::TYPE_RAT;
          end
        endcase
        cks_sum = '0;
        queue_byte(afa_pkg::DELIM, 1'b0, 1'b0, 1'b0);
        queue_byte(len[15:8], 1'b0, 1'b0, 1'b0);
        queue_byte(len[7:0], 1'b0, 1'b0, 1'b0);
        queue_byte(ftype, 1'b0, 1'b0, 1'b1);
        queue_byte(id_next, 1'b0, 1'b0, 1'b1);
        id_next = (id_next == afa_pkg::ID_LAST) ? afa_pkg::ID_FIRST : id_next + 1'b1;
        if (kind != afa_pkg::KIND_LAT) begin
          for (int i = 0; i < 8; i++) queue_byte(a64[63 - 8 * i -: 8], 1'b0, 1'b0, 1'b1);
          queue_byte(a16[15:8], 1'b0, 1'b0, 1'b1);
          queue_byte(a16[7:0], 1'b0, 1'b0, 1'b1);
        end
        if (kind == afa_pkg::KIND_TX) begin
          queue_byte(rad, 1'b0, 1'b0, 1'b1);
          queue_byte(opt, 1'b0, 1'b0, 1'b1);
        end else begin
          if (kind == afa_pkg::KIND_RAT) queue_byte(opt, 1'b0, 1'b0, 1'b1);
          queue_byte(chi, 1'b0, 1'b0, 1'b1);
          queue_byte(clo, 1'b0, 1'b0, 1'b1);
        end
        in_frame = 1'b1;
        left_cnt = plen;
        built_cnt++;
        if (plen == 0) close_frame();
      end
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      id_next  = afa_pkg::ID_FIRST;
      left_cnt = '0;
      cks_sum  = '0;
      in_frame = 1'b0;
      dropping = 1'b0;
      frame_bytes_due.delete();
    end else begin
      // Results leaving at this edge come from earlier items, so compare before predicting.
      if (pop && !empty) begin
        checked_cnt++;
        if (frame_bytes_due.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: unexpected result byte %02h last %0b status %0b",
                     $time, out_byte, last, status);
        end else begin
          want = frame_bytes_due.pop_front();
          if (want.value !== out_byte || want.last !== last || want.status !== status) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display({"%0t: expected byte %02h last %0b status %0b, ",
                        "got byte %02h last %0b status %0b"},
                       $time, want.value, want.last, want.status, out_byte, last, status);
          end
        end
      end
      if (push && !full)
        predict_frame_bytes(req_type, frame_kind, dest_addr64, dest_addr16, radius, tx_options,
                            at_cmd_hi, at_cmd_lo, payload_len, data_byte);
    end
    due_cnt = frame_bytes_due.size();
  end

endmodule

FILE: tb/sv/api_frame_assembler_test.sv
// Testbench top for the API frame assembler: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module api_frame_assembler_test;

  localparam int MAX_PAYLOAD = 256;
  localparam int IDLE_PCT = 8;
  localparam int MIN_ITEMS = 320;
  localparam int LONG_CUT = 16;      // longer frames are cut short to keep the run compact
  localparam int QUIET_FROM = 120;
  localparam int QUIET_TO = 200;
  localparam int TAIL_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        req_type = 1'b0;
  logic [1:0]  frame_kind = '0;
  logic [63:0] dest_addr64 = '0;
  logic [15:0] dest_addr16 = '0;
  logic [7:0]  radius = '0;
  logic [7:0]  tx_options = '0;
  logic [7:0]  at_cmd_hi = '0;
  logic [7:0]  at_cmd_lo = '0;
  logic [8:0]  payload_len = '0;
  logic [7:0]  data_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last;
  logic        status;

  int fail_count;
  int pending;
  int frames_built;
  int frames_rejected;
  int bytes_checked;

  bit quiet = 1'b0;
  int items_sent = 0;

  api_frame_assembler #(.MAX_PAYLOAD(MAX_PAYLOAD)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .frame_kind(frame_kind), .dest_addr64(dest_addr64), .dest_addr16(dest_addr16),
    .radius(radius), .tx_options(tx_options), .at_cmd_hi(at_cmd_hi), .at_cmd_lo(at_cmd_lo),
    .payload_len(payload_len), .data_byte(data_byte), .empty(empty), .pop(pop),
    .out_byte(out_byte), .last(last), .status(status)
  );

  afa_frame_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) scoreboard (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_type(req_type),
    .frame_kind(frame_kind), .dest_addr64(dest_addr64), .dest_addr16(dest_addr16),
    .radius(radius), .tx_options(tx_options), .at_cmd_hi(at_cmd_hi), .at_cmd_lo(at_cmd_lo),
    .payload_len(payload_len), .data_byte(data_byte), .empty(empty), .pop(pop),
    .out_byte(out_byte), .last(last), .status(status), .fail_count(fail_count),
    .pending(pending), .frames_built(frames_built), .frames_rejected(frames_rejected),
    .bytes_checked(bytes_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver stalls now and then, except in the quiet stretch.
  always @(negedge clk) begin
    pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic int tx_limit(input logic [7:0] opt);
    return opt[afa_pkg::OPT_ENCRYPT] ? MAX_PAYLOAD - 4 : MAX_PAYLOAD;
  endfunction

  task automatic send_item(input logic rq, input logic [1:0] kind, input logic [63:0] a64,
                           input logic [15:0] a16, input logic [7:0] rad,
                           input logic [7:0] opt, input logic [7:0] chi,
                           input logic [7:0] clo, input logic [8:0] plen,
                           input logic [7:0] db);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push        <= 1'b1;
    req_type    <= rq;
    frame_kind  <= kind;
    dest_addr64 <= a64;
    dest_addr16 <= a16;
    radius      <= rad;
    tx_options  <= opt;
    at_cmd_hi   <= chi;
    at_cmd_lo   <= clo;
    payload_len <= plen;
    data_byte   <= db;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_header(input logic [1:0] kind, input logic [63:0] a64,
                             input logic [15:0] a16, input logic [7:0] rad,
                             input logic [7:0] opt, input logic [7:0] chi,
                             input logic [7:0] clo, input logic [8:0] plen);
    send_item(1'b0, kind, a64, a16, rad, opt, chi, clo, plen, 8'($urandom));
  endtask

  // The header fields of a payload item are don't-cares, so they carry noise.
  task automatic send_payload(input logic [7:0] db);
    send_item(1'b1, 2'($urandom), {$urandom, $urandom}, 16'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom), db);
  endtask

  task automatic random_frame();
    logic [1:0] kind;
    logic [7:0] opt;
    int         plen;
    int         nsend;
    int         sel;
    bit         rejected;
    kind = ($urandom_range(0, 19) == 0) ? afa_pkg::KIND_NONE : 2'($urandom_range(0, 2));
    opt  = 8'($urandom);
    sel  = $urandom_range(0, 99);
    if (sel < 30) plen = 0;
    else if (sel < 93) plen = $urandom_range(1, 10);
    else if (sel < 96) plen = $urandom_range(240, 256);
    else if (kind == afa_pkg::KIND_TX) plen = $urandom_range(tx_limit(opt) + 1, 511);
    else plen = $urandom_range(1, 10);
    rejected = (kind == afa_pkg::KIND_TX) && (plen > tx_limit(opt));
    send_header(kind, {$urandom, $urandom}, 16'($urandom), 8'($urandom), opt,
                8'($urandom), 8'($urandom), 9'(plen));
    // Mostly complete frames; long, rejected and some short ones end at the next header.
    if (kind == afa_pkg::KIND_NONE) nsend = $urandom_range(0, 1);
    else if (rejected || plen > LONG_CUT) nsend = $urandom_range(0, 3);
    else if (plen > 0 && $urandom_range(0, 99) < 12) nsend = $urandom_range(0, plen - 1);
    else nsend = plen;
    for (int i = 0; i < nsend; i++) send_payload(8'($urandom));
    // Stray payload item between frames.
    if ($urandom_range(0, 99) < 5) send_payload(8'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    send_payload(8'hA5);                                          // idle, ignored
    send_header(afa_pkg::KIND_NONE, '1, '1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 9'd3);
    send_header(afa_pkg::KIND_LAT, '0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 9'd0);
    send_header(afa_pkg::KIND_TX, '1, '1, 8'hFF, 8'hFD, 8'hFF, 8'hFF, 9'd0);
    send_header(afa_pkg::KIND_RAT, 64'h0013_A200_40A1_B2C3, 16'hFFFE, 8'h00, 8'h02,
                8'h44, 8'h42, 9'd2);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_header(afa_pkg::KIND_TX, 64'h8000_0000_0000_0001, 16'h0001, 8'h80, 8'h02,
                8'h00, 8'h00, 9'd3);
    send_payload(8'h01);
    send_payload(8'h80);
    send_payload(8'h7E);
    // Encrypted transmit one byte over its limit; the next header ends the drop early.
    send_header(afa_pkg::KIND_TX, {$urandom, $urandom}, 16'($urandom), 8'h05, 8'h02,
                8'h00, 8'h00, 9'd253);
    send_payload(8'h11);
    send_payload(8'h22);
    // Both limits exactly met; each frame is abandoned by the following header.
    send_header(afa_pkg::KIND_TX, {$urandom, $urandom}, 16'($urandom), 8'h00, 8'h00,
                8'h00, 8'h00, 9'd256);
    send_payload(8'h33);
    send_header(afa_pkg::KIND_TX, {$urandom, $urandom}, 16'($urandom), 8'h0A, 8'hFF,
                8'h00, 8'h00, 9'd252);
    send_payload(8'h44);
    send_header(afa_pkg::KIND_LAT, '0, '0, 8'h00, 8'h00, 8'h4E, 8'h49, 9'd5);
    send_payload(8'h55);
    send_header(afa_pkg::KIND_RAT, '1, 16'h0000, 8'h00, 8'hFF, 8'hFF, 8'hFF, 9'd1);
    send_payload(8'h66);
    send_header(afa_pkg::KIND_TX, '0, '0, 8'h00, 8'h00, 8'h00, 8'h00, 9'd511);
    send_header(afa_pkg::KIND_LAT, '1, '1, 8'hFF, 8'hFF, 8'h41, 8'h50, 9'd1);
    send_payload(8'hC3);
    send_payload(8'h3C);                                          // after checksum, ignored

    // Random part.
    while (items_sent < MIN_ITEMS) begin
      quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      random_frame();
    end
    quiet = 1'b0;

    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Run covered %0d assembled frames and %0d rejected transmit headers,",
             frames_built, frames_rejected);
    $display("with %0d output bytes compared against the prediction.", bytes_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/afa_pkg.sv
hw/rtl/afa_front.sv
hw/rtl/afa_cmd_queue.sv
hw/rtl/afa_back.sv
hw/rtl/api_frame_assembler.sv
hw/rtl/afa_checker.sv
tb/sv/afa_frame_checker.sv
tb/sv/api_frame_assembler_test.sv
